// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SDST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/sdst_pkg.sv -----
package sdst_pkg;

  localparam int QUEUE_DEPTH_DEF = 2048;
  localparam int BLK_LEN         = 512;

  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_STOP       = 6'd12;
  localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_ONE   = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI = 6'd18;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;
  localparam logic [5:0] CMD_READ_OCR   = 6'd58;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_push_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] head_byte;
  } q_stat_t;

  typedef struct packed {
    logic        miso;
    logic        fetch_request;
    logic [31:0] fetch_block;
  } res_t;

endpackage

// ----- hdl/sd_card_spi_target_top.sv -----
// SD card in SPI mode, card side. Each input beat is either a pin sample tick
// (tuser 0) or one storage byte of a requested block (tuser 1), and each
// accepted beat yields one result beat with the MISO level and any fetch
// request. A response of more than one byte holds off the input while its
// later bytes are written, since the reply queue memory has one write port,
// and a tick that arrives while a requested block is still incomplete waits
// while each missing byte is written as zero and then the closing FF FF.
// The reply ring needs no clearing pass after reset. Two result beats can wait
// at the output before the input stalls.
module sd_card_spi_target_top #(
  parameter int QUEUE_DEPTH = sdst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] chip_select_n, [1] sclk, [2] mosi, [10:3] data_byte, [15:11] zero
  input  logic [15:0] in_tdata,
  // [0] operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] miso, [1] fetch_request, [33:2] fetch_block, [39:34] zero
  output logic [39:0] out_tdata
);
  import sdst_pkg::*;

  q_push_t    push;
  q_stat_t    qstat;
  logic       pop;
  res_t       res;
  logic       busy, fill_pending;
  logic       item_go, zfill_go;
  res_t       slot_a_r, slot_a_nxt, slot_b_r, slot_b_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_pop;

  assign in_tready = (cnt_r != 2'd2) && !busy && !(fill_pending && !in_tuser);
  assign item_go   = in_tvalid && in_tready;
  assign zfill_go  = in_tvalid && !in_tuser && fill_pending && !busy;

  sdst_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (qstat)
  );

  sdst_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_go      (item_go),
    .zfill_go     (zfill_go),
    .op           (in_tuser),
    .cs_n         (in_tdata[0]),
    .sclk         (in_tdata[1]),
    .mosi         (in_tdata[2]),
    .data_byte    (in_tdata[10:3]),
    .qstat        (qstat),
    .push         (push),
    .pop          (pop),
    .res          (res),
    .busy         (busy),
    .fill_pending (fill_pending)
  );

  assign out_pop = (cnt_r != 2'd0) && out_tready;

  always_comb begin
    slot_a_nxt = slot_a_r;
    slot_b_nxt = slot_b_r;
    cnt_nxt    = cnt_r;
    if (item_go && !out_pop) begin
      if (cnt_r == 2'd0) slot_a_nxt = res;
      else slot_b_nxt = res;
      cnt_nxt = cnt_r + 2'd1;
    end else if (!item_go && out_pop) begin
      slot_a_nxt = slot_b_r;
      cnt_nxt    = cnt_r - 2'd1;
    end else if (item_go && out_pop) begin
      if (cnt_r == 2'd1) begin
        slot_a_nxt = res;
      end else begin
        slot_a_nxt = slot_b_r;
        slot_b_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_a_r <= slot_a_nxt;
    slot_b_r <= slot_b_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {6'b0, slot_a_r.fetch_block, slot_a_r.fetch_request, slot_a_r.miso};

endmodule

// ----- hdl/sdst_queue.sv -----
module sdst_queue #(
  parameter int QUEUE_DEPTH = sdst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sdst_pkg::q_push_t push,
  input  logic             pop,
  output sdst_pkg::q_stat_t stat
);
  import sdst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_inc, head_inc;
  logic             wr_ok;
  logic [7:0]       rd_q;
  logic             fwd_r;
  logic [7:0]       fwd_d_r;

  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  // A push that would make the ring look empty is dropped.
  assign wr_ok    = push.valid && (tail_inc != head_r);
  assign tail_nxt = wr_ok ? tail_inc : tail_r;
  assign head_nxt = pop ? head_inc : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fwd_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fwd_r  <= wr_ok && (tail_r == head_nxt);
    end
  end

  // The read port always tracks the next head so the head byte is ready.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[tail_r] <= push.data;
    end
    rd_q    <= mem[head_nxt];
    fwd_d_r <= push.data;
  end

  assign stat.empty     = (head_r == tail_r);
  assign stat.head_byte = fwd_r ? fwd_d_r : rd_q;

endmodule

// ----- hdl/sdst_engine.sv -----
module sdst_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_go,
  input  logic              zfill_go,
  input  logic              op,
  input  logic              cs_n,
  input  logic              sclk,
  input  logic              mosi,
  input  logic [7:0]        data_byte,
  input  sdst_pkg::q_stat_t qstat,
  output sdst_pkg::q_push_t push,
  output logic              pop,
  output sdst_pkg::res_t    res,
  output logic              busy,
  output logic              fill_pending
);
  import sdst_pkg::*;

  localparam int FILL_W = $clog2(BLK_LEN + 1);
  localparam int BLK_SH = $clog2(BLK_LEN);

  localparam logic [7:0] R1_READY  = 8'h00;
  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_ILLEGAL = 8'h04;
  localparam logic [7:0] TOKEN     = 8'hFE;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] CHECK_PAT = 8'hAA;
  localparam logic [7:0] OCR_CCS   = 8'h40;
  localparam logic [7:0] POLL_STOP = 8'h4C;

  logic              selected_r, selected_nxt;
  logic              last_sclk_r, last_sclk_nxt;
  logic [2:0]        frame_count_r, frame_count_nxt;
  logic [7:0]        fb_r [0:4];
  logic [7:0]        fb_nxt [0:4];
  logic [7:0]        rx_shift_r, rx_shift_nxt;
  logic [2:0]        rx_count_r, rx_count_nxt;
  logic [7:0]        tx_shift_r, tx_shift_nxt;
  logic [3:0]        tx_index_r, tx_index_nxt;
  logic              tx_valid_r, tx_valid_nxt;
  logic              app_r, app_nxt;
  logic              ready_r, ready_nxt;
  logic              baddr_r, baddr_nxt;
  logic              poll_r, poll_nxt;
  logic              multi_r, multi_nxt;
  logic [31:0]       next_block_r, next_block_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              miso_r, miso_nxt;
  logic [7:0]        pbuf_r [0:3];
  logic [7:0]        pbuf_nxt [0:3];
  logic [2:0]        pcnt_r, pcnt_nxt;

  logic [7:0]  plist [0:4];
  logic [2:0]  pn;
  logic        req;
  logic [31:0] req_blk;
  logic [7:0]  rb;
  logic [3:0]  rx_inc;
  logic        do_frame;
  logic [31:0] arg, blk_of;
  logic        fill_go;
  logic [7:0]  fill_val;

  assign fill_go  = zfill_go || (item_go && op);
  assign fill_val = zfill_go ? 8'h00 : data_byte;

  always_comb begin
    selected_nxt    = selected_r;
    last_sclk_nxt   = last_sclk_r;
    frame_count_nxt = frame_count_r;
    for (int i = 0; i < 5; i++) fb_nxt[i] = fb_r[i];
    rx_shift_nxt    = rx_shift_r;
    rx_count_nxt    = rx_count_r;
    tx_shift_nxt    = tx_shift_r;
    tx_index_nxt    = tx_index_r;
    tx_valid_nxt    = tx_valid_r;
    app_nxt         = app_r;
    ready_nxt       = ready_r;
    baddr_nxt       = baddr_r;
    poll_nxt        = poll_r;
    multi_nxt       = multi_r;
    next_block_nxt  = next_block_r;
    fill_nxt        = fill_r;
    miso_nxt        = miso_r;
    for (int i = 0; i < 5; i++) plist[i] = 8'h00;
    pn       = 3'd0;
    req      = 1'b0;
    req_blk  = 32'd0;
    pop      = 1'b0;
    rb       = 8'h00;
    rx_inc   = 4'd0;
    do_frame = 1'b0;
    arg      = 32'd0;
    blk_of   = 32'd0;

    if (fill_go) begin
      if (fill_r != '0) begin
        plist[pn] = fill_val; pn = pn + 3'd1;
        fill_nxt = fill_r - 1'b1;
        if (fill_nxt == '0) begin
          plist[pn] = IDLE_BYTE; pn = pn + 3'd1;
          plist[pn] = IDLE_BYTE; pn = pn + 3'd1;
        end
      end
    end else if (item_go) begin
      if (cs_n) begin
        if (selected_r) begin
          selected_nxt = 1'b0; frame_count_nxt = 3'd0; rx_shift_nxt = 8'h00;
          rx_count_nxt = 3'd0; poll_nxt = 1'b0; tx_valid_nxt = 1'b0;
          tx_index_nxt = 4'd0; multi_nxt = 1'b0;
        end
        miso_nxt = 1'b1;
      end else begin
        if (!selected_r) begin
          frame_count_nxt = 3'd0; rx_shift_nxt = 8'h00; rx_count_nxt = 3'd0;
          poll_nxt = 1'b0; tx_valid_nxt = 1'b0; tx_index_nxt = 4'd0;
          miso_nxt = 1'b1;
        end
        selected_nxt = 1'b1;
        if (!sclk) begin
          if (!tx_valid_nxt || tx_index_nxt >= 4'd8) begin
            pop = !qstat.empty;
            tx_shift_nxt = qstat.empty ? IDLE_BYTE : qstat.head_byte;
            tx_valid_nxt = 1'b1;
            tx_index_nxt = 4'd0;
          end
          miso_nxt = tx_shift_nxt[3'd7 - tx_index_nxt[2:0]];
        end else if (!last_sclk_r) begin
          rb = {rx_shift_nxt[6:0], mosi};
          rx_inc = {1'b0, rx_count_nxt} + 4'd1;
          rx_shift_nxt = rb;
          rx_count_nxt = rx_inc[2:0];
          if (tx_valid_nxt && tx_index_nxt < 4'd8) begin
            tx_index_nxt = tx_index_nxt + 4'd1;
            if (tx_index_nxt >= 4'd8) tx_valid_nxt = 1'b0;
          end
          if (rx_inc[3]) begin
            rx_shift_nxt = 8'h00;
            rx_count_nxt = 3'd0;
            do_frame = 1'b1;
            // An idle byte on an empty queue during a multi-block read polls
            // for the next block; the byte after it starts the block unless it is 4C, which opens a command frame.
            if (multi_r && qstat.empty && frame_count_nxt == 3'd0) begin
              if (poll_nxt) begin
                poll_nxt = 1'b0;
                if (rb == POLL_STOP) begin
                  fb_nxt[0] = rb; frame_count_nxt = 3'd1; do_frame = 1'b0;
                end else begin
                  plist[pn] = TOKEN; pn = pn + 3'd1;
                  fill_nxt = FILL_W'(BLK_LEN);
                  req = 1'b1; req_blk = next_block_r;
                  next_block_nxt = next_block_r + 32'd1;
                  if (rb == IDLE_BYTE) do_frame = 1'b0;
                end
              end else if (rb == IDLE_BYTE) begin
                poll_nxt = 1'b1; do_frame = 1'b0;
              end
            end
            if (do_frame) begin
              if (frame_count_nxt == 3'd0) begin
                if (rb[7:6] == 2'b01) begin
                  fb_nxt[0] = rb; frame_count_nxt = 3'd1;
                end
              end else if (frame_count_nxt < 3'd5) begin
                fb_nxt[frame_count_nxt] = rb;
                frame_count_nxt = frame_count_nxt + 3'd1;
              end else begin
                frame_count_nxt = 3'd0;
                arg = {fb_nxt[1], fb_nxt[2], fb_nxt[3], fb_nxt[4]};
                blk_of = baddr_r ? arg : (arg >> BLK_SH);
                unique case (fb_nxt[0][5:0])
                  CMD_GO_IDLE: begin
                    app_nxt = 1'b0; ready_nxt = 1'b0; multi_nxt = 1'b0;
                    plist[0] = R1_IDLE; pn = 3'd1;
                  end
                  CMD_SEND_IF: begin
                    plist[0] = R1_IDLE; plist[1] = 8'h00; plist[2] = 8'h00;
                    plist[3] = R1_IDLE; plist[4] = CHECK_PAT; pn = 3'd5;
                  end
                  CMD_STOP: begin
                    multi_nxt = 1'b0; poll_nxt = 1'b0;
                    plist[0] = IDLE_BYTE; plist[1] = R1_READY; pn = 3'd2;
                  end
                  CMD_SET_BLKLEN: begin
                    plist[0] = R1_READY; pn = 3'd1;
                  end
                  CMD_READ_ONE: begin
                    plist[0] = R1_READY; plist[1] = TOKEN; pn = 3'd2;
                    fill_nxt = FILL_W'(BLK_LEN);
                    req = 1'b1; req_blk = blk_of;
                  end
                  CMD_READ_MULTI: begin
                    multi_nxt = 1'b1; poll_nxt = 1'b0;
                    plist[0] = R1_READY; plist[1] = TOKEN; pn = 3'd2;
                    fill_nxt = FILL_W'(BLK_LEN);
                    req = 1'b1; req_blk = blk_of;
                    next_block_nxt = blk_of + 32'd1;
                  end
                  CMD_APP: begin
                    app_nxt = 1'b1;
                    plist[0] = ready_r ? R1_READY : R1_IDLE; pn = 3'd1;
                  end
                  CMD_READ_OCR: begin
                    baddr_nxt = 1'b1;
                    plist[0] = R1_READY; plist[1] = OCR_CCS; plist[2] = 8'h00;
                    plist[3] = 8'h00; plist[4] = 8'h00; pn = 3'd5;
                  end
                  CMD_APP_OP: begin
                    if (app_r) begin
                      ready_nxt = 1'b1; app_nxt = 1'b0;
                      plist[0] = R1_READY;
                    end else begin
                      plist[0] = R1_ILLEGAL;
                    end
                    pn = 3'd1;
                  end
                  default: begin
                    plist[0] = R1_ILLEGAL; pn = 3'd1;
                  end
                endcase
              end
            end
          end
        end
        last_sclk_nxt = sclk;
      end
    end
  end

  // Response bytes go to the queue one per cycle; the rest wait here.
  always_comb begin
    for (int i = 0; i < 4; i++) pbuf_nxt[i] = pbuf_r[i];
    pcnt_nxt   = pcnt_r;
    push.valid = 1'b0;
    push.data  = 8'h00;
    if (pcnt_r != 3'd0) begin
      push.valid = 1'b1;
      push.data  = pbuf_r[0];
      pbuf_nxt[0] = pbuf_r[1];
      pbuf_nxt[1] = pbuf_r[2];
      pbuf_nxt[2] = pbuf_r[3];
      pcnt_nxt    = pcnt_r - 3'd1;
    end else if (pn != 3'd0) begin
      push.valid = 1'b1;
      push.data  = plist[0];
      for (int i = 0; i < 4; i++) pbuf_nxt[i] = plist[i+1];
      pcnt_nxt = pn - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selected_r    <= 1'b0;
      last_sclk_r   <= 1'b0;
      frame_count_r <= 3'd0;
      rx_shift_r    <= 8'h00;
      rx_count_r    <= 3'd0;
      tx_shift_r    <= 8'h00;
      tx_index_r    <= 4'd0;
      tx_valid_r    <= 1'b0;
      app_r         <= 1'b0;
      ready_r       <= 1'b0;
      baddr_r       <= 1'b0;
      poll_r        <= 1'b0;
      multi_r       <= 1'b0;
      next_block_r  <= 32'd0;
      fill_r        <= '0;
      miso_r        <= 1'b1;
      pcnt_r        <= 3'd0;
    end else begin
      selected_r    <= selected_nxt;
      last_sclk_r   <= last_sclk_nxt;
      frame_count_r <= frame_count_nxt;
      rx_shift_r    <= rx_shift_nxt;
      rx_count_r    <= rx_count_nxt;
      tx_shift_r    <= tx_shift_nxt;
      tx_index_r    <= tx_index_nxt;
      tx_valid_r    <= tx_valid_nxt;
      app_r         <= app_nxt;
      ready_r       <= ready_nxt;
      baddr_r       <= baddr_nxt;
      poll_r        <= poll_nxt;
      multi_r       <= multi_nxt;
      next_block_r  <= next_block_nxt;
      fill_r        <= fill_nxt;
      miso_r        <= miso_nxt;
      pcnt_r        <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) fb_r[i] <= fb_nxt[i];
    for (int i = 0; i < 4; i++) pbuf_r[i] <= pbuf_nxt[i];
  end

  assign res.miso          = miso_nxt;
  assign res.fetch_request = req;
  assign res.fetch_block   = req_blk;
  assign busy              = (pcnt_r != 3'd0);
  assign fill_pending      = (fill_r != '0);

endmodule

// ----- hdl/sdst_checker.sv -----
`include "assert_macros.svh"

module sdst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result beat keeps its payload.
  `SDST_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Without a fetch request the block index reads as zero.
  `SDST_ASSERT_IMP(a_blk_zero, out_tvalid && !out_tdata[1], out_tdata[33:2] == 32'd0)

  // Nothing is offered right after reset is released.
  `SDST_ASSERT_IMP(a_reset_quiet, !$past(rst_n), !out_tvalid)

  // A deselected tick sends the idle level on MISO.
  `SDST_ASSERT_NXT(a_desel_idle,
    in_tvalid && in_tready && !in_tuser && in_tdata[0] && !out_tvalid,
    out_tvalid && out_tdata[0])

endmodule

bind sd_card_spi_target_top sdst_checker u_sdst_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sdst_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_DATA = 1'b1;
  localparam logic [5:0] CMD_UNKNOWN = 6'd1;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 260;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;

  sd_card_spi_target_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Card state as the host side expects it.
  logic sel, last_sck, multi, poll_wait, app_wait, ready, blk_addr, tx_live;
  logic [7:0] frame[6];
  int frame_cnt, rx_cnt, tx_bit, fill_left;
  logic [7:0] rx_byte, tx_byte;
  logic pin_miso;
  logic [7:0] replies[QDEPTH];
  int q_head, q_tail;
  logic [31:0] next_blk;
  logic req_now;
  logic [31:0] req_idx;

  res_t card_results[$];
  int errors = 0;
  int cycles = 0;
  int items = 0;
  bit idle_on = 1'b1;

  function int q_used();
    return (q_tail + QDEPTH - q_head) % QDEPTH;
  endfunction

  function void q_put(logic [7:0] v);
    if ((q_tail + 1) % QDEPTH == q_head) return;
    replies[q_tail] = v;
    q_tail = (q_tail + 1) % QDEPTH;
  endfunction

  function logic [7:0] q_take();
    logic [7:0] v;
    if (q_head == q_tail) return 8'hFF;
    v = replies[q_head];
    q_head = (q_head + 1) % QDEPTH;
    return v;
  endfunction

  function void open_block(logic [31:0] idx);
    q_put(8'hFE);
    fill_left = BLK_LEN;
    req_now = 1'b1;
    req_idx = idx;
  endfunction

  function void fill_one(logic [7:0] b);
    if (fill_left == 0) return;
    q_put(b);
    fill_left--;
    if (fill_left == 0) begin
      q_put(8'hFF);
      q_put(8'hFF);
    end
  endfunction

  function void deselect();
    sel = 1'b0;
    frame_cnt = 0;
    rx_byte = '0;
    rx_cnt = 0;
    poll_wait = 1'b0;
    tx_live = 1'b0;
    tx_bit = 0;
    pin_miso = 1'b1;
  endfunction

  function void shift_out();
    if (!tx_live || tx_bit >= 8) begin
      tx_byte = q_take();
      tx_live = 1'b1;
      tx_bit = 0;
    end
    pin_miso = tx_byte[7 - tx_bit];
  endfunction

  function void execute();
    logic [5:0] c;
    logic [31:0] a;
    c = frame[0][5:0];
    a = {frame[1], frame[2], frame[3], frame[4]};
    frame_cnt = 0;
    case (c)
      CMD_GO_IDLE: begin
        app_wait = 0; ready = 0; multi = 0;
        q_put(8'h01);
      end
      CMD_SEND_IF: begin
        q_put(8'h01); q_put(8'h00); q_put(8'h00); q_put(8'h01); q_put(8'hAA);
      end
      CMD_STOP: begin
        multi = 0; poll_wait = 0;
        q_put(8'hFF); q_put(8'h00);
      end
      CMD_SET_BLKLEN: q_put(8'h00);
      CMD_READ_ONE: begin
        q_put(8'h00);
        open_block(blk_addr ? a : a / BLK_LEN);
      end
      CMD_READ_MULTI: begin
        multi = 1; poll_wait = 0;
        next_blk = blk_addr ? a : a / BLK_LEN;
        q_put(8'h00);
        open_block(next_blk);
        next_blk++;
      end
      CMD_APP: begin
        app_wait = 1;
        q_put(ready ? 8'h00 : 8'h01);
      end
      CMD_READ_OCR: begin
        blk_addr = 1;
        q_put(8'h00); q_put(8'h40); q_put(8'h00); q_put(8'h00); q_put(8'h00);
      end
      CMD_APP_OP: begin
        if (app_wait) begin
          ready = 1; app_wait = 0;
          q_put(8'h00);
        end else begin
          q_put(8'h04);
        end
      end
      default: q_put(8'h04);
    endcase
  endfunction

  function void take_byte(logic [7:0] b);
    if (multi && q_used() == 0 && frame_cnt == 0) begin
      if (poll_wait) begin
        poll_wait = 0;
        if (b == 8'h4C) begin
          frame[0] = b;
          frame_cnt = 1;
          return;
        end
        open_block(next_blk);
        next_blk++;
        if (b == 8'hFF) return;
      end else if (b == 8'hFF) begin
        poll_wait = 1;
        return;
      end
    end
    if (frame_cnt == 0) begin
      if (b[7:6] == 2'b01) begin
        frame[0] = b;
        frame_cnt = 1;
      end
      return;
    end
    if (frame_cnt < 6) frame[frame_cnt] = b;
    frame_cnt++;
    if (frame_cnt >= 6) execute();
  endfunction

  function res_t card_step(logic op, logic cs_n, logic sck, logic mo, logic [7:0] db);
    res_t r;
    req_now = 0;
    req_idx = 0;
    if (op == OP_DATA) begin
      fill_one(db);
    end else begin
      while (fill_left != 0) fill_one(8'h00);
      if (cs_n) begin
        if (sel) begin
          deselect();
          multi = 0;
        end
        pin_miso = 1'b1;
      end else begin
        if (!sel) begin
          deselect();
          sel = 1;
        end
        if (!sck) shift_out();
        if (!last_sck && sck) begin
          rx_byte = {rx_byte[6:0], mo};
          rx_cnt++;
          if (tx_live && tx_bit < 8) begin
            tx_bit++;
            if (tx_bit >= 8) tx_live = 0;
          end
          if (rx_cnt >= 8) begin
            take_byte(rx_byte);
            rx_byte = 0;
            rx_cnt = 0;
          end
        end
        last_sck = sck;
        if (!sck) shift_out();
      end
    end
    r.miso = pin_miso;
    r.fetch_request = req_now;
    r.fetch_block = req_now ? req_idx : 32'd0;
    return r;
  endfunction

  function void card_reset();
    sel = 0; last_sck = 0; frame_cnt = 0; rx_byte = 0; rx_cnt = 0;
    q_head = 0; q_tail = 0; tx_byte = 0; tx_bit = 0; tx_live = 0;
    app_wait = 0; ready = 0; blk_addr = 0; poll_wait = 0; multi = 0;
    next_blk = 0; fill_left = 0; pin_miso = 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic send(logic op, logic cs_n, logic sck, logic mo, logic [7:0] db);
    while (idle_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'b0, db, mo, sck, cs_n};
    do @(posedge clk); while (!in_tready);
    card_results.push_back(card_step(op, cs_n, sck, mo, db));
    items++;
  endtask

  task automatic tick(logic cs_n, logic sck, logic mo);
    send(OP_TICK, cs_n, sck, mo, 8'($urandom));
  endtask

  task automatic spi_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      tick(1'b0, 1'b0, b[i]);
      tick(1'b0, 1'b1, b[i]);
    end
  endtask

  task automatic spi_cmd(logic [5:0] c, logic [31:0] a);
    spi_byte({2'b01, c});
    spi_byte(a[31:24]);
    spi_byte(a[23:16]);
    spi_byte(a[15:8]);
    spi_byte(a[7:0]);
    spi_byte(8'h95);
  endtask

  task automatic supply(int n);
    repeat (n) send(OP_DATA, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sd_card_spi_target_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= !idle_on || $urandom_range(99) >= 17;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (card_results.size() == 0) begin
        report("unexpected beat", out_tdata[31:0], 32'd0);
      end else begin
        want = card_results.pop_front();
        if (out_tdata[0] !== want.miso)
          report("miso", 32'(out_tdata[0]), 32'(want.miso));
        if (out_tdata[1] !== want.fetch_request)
          report("fetch_request", 32'(out_tdata[1]), 32'(want.fetch_request));
        if (out_tdata[33:2] !== want.fetch_block)
          report("fetch_block", out_tdata[33:2], want.fetch_block);
      end
    end
  end

  task automatic test_deselected_idle();
    tick(1'b1, 1'b0, 1'b0);
    tick(1'b1, 1'b1, 1'b1);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b1, 1'b0);
    send(OP_DATA, 1'b0, 1'b0, 1'b0, 8'hA5);
  endtask

  task automatic test_single_read();
    // Byte addressing is still in force, so the argument is divided by the block size.
    spi_cmd(CMD_READ_ONE, 32'h0000_0400);
    supply(3);
    tick(1'b0, 1'b0, 1'b1);
    send(OP_DATA, 1'b0, 1'b0, 1'b0, 8'hFF);
  endtask

  task automatic test_commands();
    idle_on = 1'b0;
    spi_cmd(CMD_GO_IDLE, 32'h0);
    spi_cmd(CMD_APP_OP, 32'h0);
    spi_cmd(CMD_APP, 32'h0);
    spi_cmd(CMD_APP_OP, 32'h4000_0000);
    spi_cmd(CMD_READ_OCR, 32'h0);
    spi_cmd(CMD_READ_ONE, 32'hFFFF_FFFF);
    tick(1'b0, 1'b0, 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_multi_read();
    spi_cmd(CMD_READ_MULTI, 32'hFFFF_FFFE);
    tick(1'b0, 1'b0, 1'b1);
    spi_byte(8'hFF);
    spi_cmd(CMD_STOP, 32'h0);
    tick(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_deselect_midbyte();
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b1, 1'b1);
    tick(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b1, 1'b1);
    tick(1'b1, 1'b0, 1'b0);
    tick(1'b1, 1'b1, 1'b1);
    spi_cmd(CMD_SET_BLKLEN, 32'h0);
  endtask

  task automatic test_queue_full();
    repeat (2) begin
      spi_cmd(CMD_READ_ONE, 32'($urandom_range(1000)));
      tick(1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic test_random();
    logic [5:0] cmds[10];
    int start, pick;
    cmds = '{CMD_GO_IDLE, CMD_SEND_IF, CMD_STOP, CMD_SET_BLKLEN, CMD_READ_ONE,
             CMD_READ_MULTI, CMD_APP_OP, CMD_APP, CMD_READ_OCR, CMD_UNKNOWN};
    start = items;
    while (items - start < RANDOM_ITEMS) begin
      idle_on = (items - start) < RANDOM_ITEMS / 2 || (items - start) > RANDOM_ITEMS * 3 / 4;
      pick = $urandom_range(99);
      if (pick < 55) begin
        spi_cmd($urandom_range(4) == 0 ? 6'($urandom) : cmds[$urandom_range(9)],
                $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(4095)));
        if (fill_left != 0) supply($urandom_range(7) == 0 ? fill_left : $urandom_range(6));
        repeat ($urandom_range(2)) spi_byte(8'hFF);
      end else if (pick < 70) begin
        spi_byte(8'($urandom));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) tick(1'b1, 1'($urandom), 1'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) tick(1'($urandom_range(9) == 0), 1'($urandom),
                                          1'($urandom));
      end else begin
        supply($urandom_range(1, 3));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int guard;
    card_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_deselected_idle();
    test_single_read();
    test_commands();
    test_multi_read();
    test_deselect_midbyte();
    test_random();
    test_queue_full();
    in_tvalid <= 1'b0;
    guard = 0;
    while (card_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && card_results.size() == 0) begin
      $display("[sd_card_spi_target_top] OK");
    end else begin
      $display("[sd_card_spi_target_top] ERROR");
    end
    $finish;
  end

endmodule
